// ----- sv/lgrs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgrs_pkg: shared types and constants for the Life row stream
// Word widths, register indexes, reset values and the structs passed between
// the cell chain, the output queue and the top level.
// ----------------------------------------------------------------------------
package lgrs_pkg;

  // Word and field widths.
  localparam int unsigned RowW     = 64;
  localparam int unsigned RowIdxW  = 16;
  localparam int unsigned ColsW    = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegGridRows = 1'b0;
  localparam logic [CfgIdxW-1:0] RegGridCols = 1'b1;

  // Register reset values.
  localparam logic [RowIdxW-1:0] GridRowsRst = 16'd8;
  localparam logic [ColsW-1:0]   GridColsRst = 7'd5;

  // Output queue depth; an input word is taken only while two slots are free.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Masked bits that one cell shows to its two neighbors.
  typedef struct packed {
    logic upper;
    logic middle;
    logic row;
  } lgrs_nbr_t;

  // Control shared by every cell of the chain.
  typedef struct packed {
    logic load;   // an input word is accepted this cycle
    logic last;   // the accepted word is the final row of the frame
  } lgrs_ctrl_t;

  // One result word held in the output queue.
  typedef struct packed {
    logic [RowW-1:0]    next_cells;
    logic [RowIdxW-1:0] out_row;
    logic               frame_done;
  } lgrs_res_t;

endpackage

// ----- sv/lgrs_cell.sv -----
// ----------------------------------------------------------------------------
// lgrs_cell: one column of the Life generation chain
// Holds the column's bits of the two pending rows, shares them with the
// neighboring columns and forms both next-generation bits for this column.
// ----------------------------------------------------------------------------
module lgrs_cell
  import lgrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lgrs_ctrl_t ctrl_i,
  input  logic       en_i,
  input  logic       row_bit_i,
  input  lgrs_nbr_t  left_i,
  input  lgrs_nbr_t  right_i,
  output lgrs_nbr_t  own_o,
  output logic       next_bit_o,
  output logic       final_bit_o
);

  logic       upper_q, upper_d;
  logic       middle_q, middle_d;
  logic [3:0] cnt_mid;
  logic [3:0] cnt_fin;

  // Columns beyond the active width read as dead.
  always_comb begin
    own_o.upper  = upper_q & en_i;
    own_o.middle = middle_q & en_i;
    own_o.row    = row_bit_i & en_i;
  end

  // Neighbor count for the pending row, with the new word below it.
  assign cnt_mid = 4'(left_i.upper) + 4'(own_o.upper) + 4'(right_i.upper)
                 + 4'(left_i.middle) + 4'(right_i.middle)
                 + 4'(left_i.row) + 4'(own_o.row) + 4'(right_i.row);

  // Neighbor count for the final row: pending row above, dead row below.
  assign cnt_fin = 4'(left_i.middle) + 4'(own_o.middle) + 4'(right_i.middle)
                 + 4'(left_i.row) + 4'(right_i.row);

  // Birth on three, survival on two or three.
  assign next_bit_o  = en_i & ((cnt_mid == 4'd3) | ((cnt_mid == 4'd2) & own_o.middle));
  assign final_bit_o = en_i & ((cnt_fin == 4'd3) | ((cnt_fin == 4'd2) & own_o.row));

  // Shift the row history, or clear it at the end of a frame. The upper bit
  // takes the unmasked middle bit, the middle bit takes the masked new bit.
  always_comb begin
    upper_d  = upper_q;
    middle_d = middle_q;
    if (ctrl_i.load) begin
      if (ctrl_i.last) begin
        upper_d  = 1'b0;
        middle_d = 1'b0;
      end else begin
        upper_d  = middle_q;
        middle_d = own_o.row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q  <= 1'b0;
      middle_q <= 1'b0;
    end else begin
      upper_q  <= upper_d;
      middle_q <= middle_d;
    end
  end

endmodule

// ----- sv/lgrs_out_fifo.sv -----
// ----------------------------------------------------------------------------
// lgrs_out_fifo: result queue of the Life row stream
// Takes up to two result words per cycle, in order, and hands them out one
// per cycle on the valid/stall output channel when the output is not stalled.
// ----------------------------------------------------------------------------
module lgrs_out_fifo
  import lgrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_a_i,
  input  lgrs_res_t data_a_i,
  input  logic      push_b_i,
  input  lgrs_res_t data_b_i,
  input  logic      pop_i,
  output logic      room_o,
  output logic      valid_o,
  output lgrs_res_t head_o
);

  lgrs_res_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic [FifoPtrW-1:0]   wr_b_ptr;
  logic [FifoCntW-1:0]   n_push;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= FifoCntW'(FifoDepth - 2));
  assign head_o  = mem_q[rd_ptr_q];

  // The second word lands after the first one when both are written.
  assign wr_b_ptr = wr_ptr_q + FifoPtrW'(push_a_i);
  assign n_push   = FifoCntW'(push_a_i) + FifoCntW'(push_b_i);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrW'(n_push);
    rd_ptr_d = rd_ptr_q + FifoPtrW'(pop_i);
    cnt_d    = cnt_q + n_push - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage for the result words.
  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wr_ptr_q] <= data_a_i;
    end
    if (push_b_i) begin
      mem_q[wr_b_ptr] <= data_b_i;
    end
  end

endmodule

// ----- sv/life_generation_row_stream.sv -----
// ----------------------------------------------------------------------------
// life_generation_row_stream: one Game of Life generation over streamed rows
// A chain of column cells keeps the two most recent rows and forms the next
// generation (birth on three, survival on two or three neighbors) as each
// new row word arrives; results leave through a small output queue.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_stall_o   row_cells_i
//   output   out        out_valid_o / out_stall_i next_cells_o, out_row_o,
//                                                 frame_done_o
//   config   in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One input word is taken per cycle while the input is not stalled; its results
// are in the queue in the next cycle and leave one per cycle while the output
// is not stalled. Except in a one-row frame, the final row of a frame gives two
// results and the first row none, so a frame of R rows gives R results. Input
// stalls while fewer than two queue slots are free. Reset clears the row
// history, the row counter and the queue at once; no clearing pass follows.
// ----------------------------------------------------------------------------
module life_generation_row_stream
  import lgrs_pkg::*;
#(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 65535
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [RowW-1:0]     row_cells_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RowW-1:0]     next_cells_o,
  output logic [RowIdxW-1:0]  out_row_o,
  output logic                frame_done_o
);

  logic [RowIdxW-1:0] grid_rows_q;
  logic [ColsW-1:0]   grid_cols_q;
  logic [RowIdxW-1:0] row_cnt_q, row_cnt_d;
  logic [RowIdxW-1:0] rows_eff;
  logic [RowIdxW-1:0] last_idx;
  logic [ColsW-1:0]   cols_eff;
  logic               in_acc;
  logic               fifo_room;
  lgrs_ctrl_t         ctrl;
  lgrs_nbr_t          nbr [MAX_COLS];
  logic [MAX_COLS-1:0] next_bits;
  logic [MAX_COLS-1:0] final_bits;
  lgrs_res_t          res_a;
  lgrs_res_t          res_b;
  lgrs_res_t          head;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= GridRowsRst;
      grid_cols_q <= GridColsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegGridRows: grid_rows_q <= cfg_wdata_i;
        RegGridCols: grid_cols_q <= cfg_wdata_i[ColsW-1:0];
        default:     ;
      endcase
    end
  end

  // Effective grid size: zero rows counts as one, both sizes saturate.
  always_comb begin
    if (grid_rows_q == '0) begin
      rows_eff = RowIdxW'(1);
    end else if (grid_rows_q > RowIdxW'(MAX_ROWS)) begin
      rows_eff = RowIdxW'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows_q;
    end
    cols_eff = (grid_cols_q > ColsW'(MAX_COLS)) ? ColsW'(MAX_COLS) : grid_cols_q;
  end

  assign last_idx   = rows_eff - RowIdxW'(1);
  assign in_stall_o = !fifo_room;
  assign in_acc     = in_valid_i && fifo_room;

  always_comb begin
    ctrl.load = in_acc;
    ctrl.last = (row_cnt_q >= last_idx);
  end

  // Row counter: index of the next expected input row.
  always_comb begin
    row_cnt_d = row_cnt_q;
    if (in_acc) begin
      row_cnt_d = ctrl.last ? '0 : row_cnt_q + RowIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
    end else begin
      row_cnt_q <= row_cnt_d;
    end
  end

  // Chain of column cells; the grid edges see dead neighbors.
  for (genvar j = 0; j < MAX_COLS; j++) begin : g_col
    lgrs_nbr_t left_n;
    lgrs_nbr_t right_n;

    if (j == 0) begin : g_lo_edge
      assign left_n = '0;
    end else begin : g_lo_link
      assign left_n = nbr[j-1];
    end

    if (j == MAX_COLS - 1) begin : g_hi_edge
      assign right_n = '0;
    end else begin : g_hi_link
      assign right_n = nbr[j+1];
    end

    lgrs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .en_i        (ColsW'(j) < cols_eff),
      .row_bit_i   (row_cells_i[j]),
      .left_i      (left_n),
      .right_i     (right_n),
      .own_o       (nbr[j]),
      .next_bit_o  (next_bits[j]),
      .final_bit_o (final_bits[j])
    );
  end

  // Result words: the pending row, then the final row at a frame end.
  always_comb begin
    res_a.next_cells = RowW'(next_bits);
    res_a.out_row    = row_cnt_q - RowIdxW'(1);
    res_a.frame_done = 1'b0;
    res_b.next_cells = RowW'(final_bits);
    res_b.out_row    = row_cnt_q;
    res_b.frame_done = 1'b1;
  end

  lgrs_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (in_acc && (row_cnt_q != '0)),
    .data_a_i (res_a),
    .push_b_i (in_acc && ctrl.last),
    .data_b_i (res_b),
    .pop_i    (out_valid_o && !out_stall_i),
    .room_o   (fifo_room),
    .valid_o  (out_valid_o),
    .head_o   (head)
  );

  assign next_cells_o = head.next_cells;
  assign out_row_o    = head.out_row;
  assign frame_done_o = head.frame_done;

endmodule

// ----- sv/lgrs_checker.sv -----
// ----------------------------------------------------------------------------
// lgrs_checker: port-level checks for the Life row stream
// Watches the top level's ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module lgrs_checker
  import lgrs_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [RowW-1:0]     next_cells_o,
  input logic [RowIdxW-1:0]  out_row_o,
  input logic                frame_done_o
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(next_cells_o) && $stable(out_row_o) && $stable(frame_done_o))
    else $error("output payload changed while stalled");

  // With no result waiting the queue has room, so input is never stalled.
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty result queue");

  // Row indexes stay below the largest grid size.
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_row_o != 16'hFFFF)
    else $error("result row index out of range");

endmodule

bind life_generation_row_stream lgrs_checker u_lgrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .next_cells_o (next_cells_o),
  .out_row_o    (out_row_o),
  .frame_done_o (frame_done_o)
);
